// ===== rtl/integer_field_formatter_core_macros.svh =====
// assertion helpers for the formatter core
`ifndef INTEGER_FIELD_FORMATTER_CORE_MACROS_SVH
`define INTEGER_FIELD_FORMATTER_CORE_MACROS_SVH

// implication checked on every clock edge outside reset
`define IFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must never hold outside reset
`define IFF_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== rtl/iff_pkg.sv =====
`default_nettype none

package iff_pkg;

  localparam int ValueBits = 32;
  localparam int WidthBits = 6;
  localparam int CountBits = $clog2(ValueBits);

  // digit register: 11 nibbles hold 10 decimal, 8 hex or 11 octal digits
  localparam int DigitRegBits = 44;
  localparam int DecDigits    = 10;
  localparam int HexDigits    = ValueBits / 4;
  localparam int OctDigits    = (ValueBits + 2) / 3;
  localparam int DcountBits   = 4;

  localparam logic [2:0] KIND_SDEC = 3'd0;
  localparam logic [2:0] KIND_UDEC = 3'd1;
  localparam logic [2:0] KIND_OCT  = 3'd2;
  localparam logic [2:0] KIND_HEX  = 3'd3;
  localparam logic [2:0] KIND_CHAR = 3'd4;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharUpperA = 8'h41;

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [2:0]           conversion_kind;
    logic [WidthBits-1:0] field_width;
    logic                 left_adjust;
    logic                 zero_pad;
  } request_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } result_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CharZero + {4'b0000, d};
    end else begin
      c = CharUpperA + {4'b0000, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/integer_field_formatter_core.sv =====
// integer field formatter: turns one decoded integer conversion request into
// a run of ascii characters, one per clock, on the result port.
// request channel: a request is taken on a rising edge with start high and
// busy low; busy stays high until the last character has been sent.
// kinds 5 to 7 are dropped on acceptance and leave busy low.
// result channel: result_valid marks each character for exactly one cycle;
// last_char flags the final character of the field. there is no stall input,
// the receiver must take every character as it appears.
// sequence: numeric kinds shift the value msb first through a bit-serial
// converter (double dabble for decimal), then drop leading zero digits (at
// most 10), then send one character per cycle, max(field_width, text length)
// characters. character kind skips the converter. busy drops while the last
// character is on the port.
// reset: synchronous, active high; returns to idle, drops busy and
// result_valid, any field in progress is abandoned.
`default_nettype none

`include "integer_field_formatter_core_macros.svh"

module integer_field_formatter_core (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire iff_pkg::request_t request,
  output logic                  busy,
  output logic                  result_valid,
  output iff_pkg::result_t      result
);
  import iff_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN_A,
    S_PAD_L,
    S_SIGN_B,
    S_TEXT,
    S_PAD_R
  } state_t;

  state_t                  state;
  logic [ValueBits-1:0]    val;       // magnitude, shifted out msb first
  logic [DigitRegBits-1:0] digits;    // converted digits, top digit emitted first
  logic [CountBits-1:0]    cnt;       // conversion bit counter
  logic [DcountBits-1:0]   dcount;    // digits still to emit
  logic [WidthBits-1:0]    pcount;    // pad characters still to emit
  logic [2:0]              kind;
  logic [WidthBits-1:0]    width;
  logic                    left;
  logic                    zeros;
  logic                    neg;

  logic                    kind_ok;
  logic                    req_neg;
  logic [DigitRegBits-1:0] dec_adj;
  logic [DigitRegBits-1:0] digits_conv;
  logic [DigitRegBits-1:0] digits_shift;
  logic [3:0]              top_digit;
  logic [DcountBits-1:0]   ndig;
  logic [DcountBits-1:0]   text_len;
  logic [WidthBits-1:0]    padn;
  logic                    pad_any;
  logic                    en_sign_a;
  logic                    en_sign_b;
  logic [7:0]              pad_char;
  logic [7:0]              text_char;
  state_t                  first_phase;
  state_t                  after_pad_l;

  assign busy = (state != S_IDLE);

  // request decode
  assign kind_ok = (request.conversion_kind == KIND_SDEC) ||
                   (request.conversion_kind == KIND_UDEC) ||
                   (request.conversion_kind == KIND_OCT)  ||
                   (request.conversion_kind == KIND_HEX)  ||
                   (request.conversion_kind == KIND_CHAR);
  assign req_neg = (request.conversion_kind == KIND_SDEC) && request.value[ValueBits-1];

  always_comb begin
    unique case (request.conversion_kind)
      KIND_SDEC, KIND_UDEC: ndig = DcountBits'(DecDigits);
      KIND_OCT:             ndig = DcountBits'(OctDigits);
      KIND_HEX:             ndig = DcountBits'(HexDigits);
      default:              ndig = DcountBits'(1);
    endcase
  end

  // double dabble correction, one add-3 per bcd nibble
  always_comb begin
    dec_adj = digits;
    for (int i = 0; i < DecDigits; i++) begin
      if (digits[4*i +: 4] >= 4'd5) begin
        dec_adj[4*i +: 4] = digits[4*i +: 4] + 4'd3;
      end
    end
  end

  // shift in the next value bit; hex and octal need no correction
  assign digits_conv = (kind == KIND_SDEC || kind == KIND_UDEC) ?
                       {dec_adj[DigitRegBits-2:0], val[ValueBits-1]} :
                       {digits[DigitRegBits-2:0], val[ValueBits-1]};

  // top digit sits at a fixed place per kind; emitting shifts one digit up
  always_comb begin
    unique case (kind)
      KIND_OCT: begin
        top_digit    = {1'b0, digits[3*OctDigits-1 -: 3]};
        digits_shift = {digits[DigitRegBits-4:0], 3'b000};
      end
      KIND_HEX: begin
        top_digit    = digits[4*HexDigits-1 -: 4];
        digits_shift = {digits[DigitRegBits-5:0], 4'b0000};
      end
      default: begin
        top_digit    = digits[4*DecDigits-1 -: 4];
        digits_shift = {digits[DigitRegBits-5:0], 4'b0000};
      end
    endcase
  end

  // field layout
  assign text_len  = dcount + DcountBits'(neg);
  assign padn      = (width > WidthBits'(text_len)) ? (width - WidthBits'(text_len)) : '0;
  assign pad_any   = (state == S_SKIP) ? (padn != '0) : (pcount != '0);
  assign en_sign_a = neg && zeros && !left;
  assign en_sign_b = neg && !en_sign_a;
  assign pad_char  = zeros ? CharZero : CharSpace;
  assign text_char = (kind == KIND_CHAR) ? val[7:0] : digit_char(top_digit);

  always_comb begin
    priority if (en_sign_a) begin
      first_phase = S_SIGN_A;
    end else if (!left && pad_any) begin
      first_phase = S_PAD_L;
    end else if (en_sign_b) begin
      first_phase = S_SIGN_B;
    end else begin
      first_phase = S_TEXT;
    end
  end

  assign after_pad_l = en_sign_b ? S_SIGN_B : S_TEXT;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start && kind_ok) begin
            val    <= req_neg ? (~request.value + ValueBits'(1)) : request.value;
            neg    <= req_neg;
            kind   <= request.conversion_kind;
            width  <= request.field_width;
            left   <= request.left_adjust;
            zeros  <= request.zero_pad;
            digits <= '0;
            cnt    <= CountBits'(ValueBits - 1);
            dcount <= ndig;
            state  <= (request.conversion_kind == KIND_CHAR) ? S_SKIP : S_CONV;
          end
        end
        S_CONV: begin
          digits <= digits_conv;
          val    <= {val[ValueBits-2:0], 1'b0};
          cnt    <= cnt - CountBits'(1);
          if (cnt == '0) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          // drop leading zero digits, keeping at least one
          if (dcount > DcountBits'(1) && top_digit == 4'd0) begin
            digits <= digits_shift;
            dcount <= dcount - DcountBits'(1);
          end else begin
            pcount <= padn;
            state  <= first_phase;
          end
        end
        S_SIGN_A: begin
          result_valid     <= 1'b1;
          result.out_char  <= CharMinus;
          result.last_char <= 1'b0;
          state            <= pad_any ? S_PAD_L : S_TEXT;
        end
        S_PAD_L: begin
          result_valid     <= 1'b1;
          result.out_char  <= pad_char;
          result.last_char <= 1'b0;
          pcount           <= pcount - WidthBits'(1);
          if (pcount == WidthBits'(1)) begin
            state <= after_pad_l;
          end
        end
        S_SIGN_B: begin
          result_valid     <= 1'b1;
          result.out_char  <= CharMinus;
          result.last_char <= 1'b0;
          state            <= S_TEXT;
        end
        S_TEXT: begin
          result_valid     <= 1'b1;
          result.out_char  <= text_char;
          result.last_char <= (dcount == DcountBits'(1)) && !(left && pad_any);
          digits           <= digits_shift;
          dcount           <= dcount - DcountBits'(1);
          if (dcount == DcountBits'(1)) begin
            state <= (left && pad_any) ? S_PAD_R : S_IDLE;
          end
        end
        S_PAD_R: begin
          result_valid     <= 1'b1;
          result.out_char  <= pad_char;
          result.last_char <= (pcount == WidthBits'(1));
          pcount           <= pcount - WidthBits'(1);
          if (pcount == WidthBits'(1)) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // a character only follows a cycle in which the core was busy
  `IFF_ASSERT(a_valid_after_busy, result_valid |-> $past(busy), "character without work")
  // a field that is not finished keeps new requests out
  `IFF_NEVER(a_no_accept_mid_field, start && !busy && result_valid && !result.last_char,
             "request accepted inside a field")
  // the last character closes the field
  `IFF_ASSERT(a_last_ends_field, (result_valid && result.last_char) |=> !result_valid,
              "character after end of field")
  // text phase never runs out of digits
  `IFF_NEVER(a_text_has_digit, state == S_TEXT && dcount == '0, "text phase with no digit")

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import iff_pkg::*;

  // kinds 5 to 7 carry no meaning: the core drops them on acceptance
  localparam logic [2:0] KIND_RSVD_A = 3'd5;
  localparam logic [2:0] KIND_RSVD_B = 3'd6;
  localparam logic [2:0] KIND_RSVD_C = 3'd7;

  localparam int RANDOM_REQUESTS = 430;
  // after the last character, enough cycles for a full conversion plus a 63-wide field
  localparam int DRAIN_CYCLES = 150;
  // watchdog bound for the whole run, well above what the requests need
  localparam int CYCLE_LIMIT = 600000;

  logic     clk;
  logic     rst;
  logic     start;
  request_t request;
  logic     busy;
  logic     result_valid;
  result_t  result;

  integer_field_formatter_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .request     (request),
    .busy        (busy),
    .result_valid(result_valid),
    .result      (result)
  );

  // characters still owed by the core, oldest first
  result_t pending_chars[$];
  int      error_count = 0;
  int      cycle_count = 0;
  // when set, the sender stops idling between requests
  bit      back_to_back = 1'b0;

  // directed table: request plus the field it must print, or "" for the predictor
  request_t row_req[$];
  string    row_text[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // queue the characters of a field written out by hand
  function automatic void queue_typed_field(input string text);
    result_t r;
    for (int i = 0; i < text.len(); i++) begin
      r.out_char  = text[i];
      r.last_char = (i == text.len() - 1);
      pending_chars.push_back(r);
    end
  endfunction

  // predicts the whole formatted field of one request and queues it
  function automatic void predict_field(input request_t req);
    string      digit_set = "0123456789ABCDEF";
    logic [7:0] body[$];
    logic [7:0] digits_rev[$];
    logic [31:0] mag;
    logic [31:0] radix;
    logic [7:0] fill;
    logic [7:0] field[$];
    bit         negative;
    bit         numeric;
    int         pad_count;
    int         skip;
    result_t    r;

    mag      = req.value;
    negative = 1'b0;
    numeric  = 1'b1;
    radix    = 32'd10;
    case (req.conversion_kind)
      KIND_SDEC: begin
        // most negative value negates to itself, whose unsigned reading is the magnitude
        negative = req.value[31];
        if (negative) mag = ~req.value + 32'd1;
      end
      KIND_UDEC: radix = 32'd10;
      KIND_OCT:  radix = 32'd8;
      KIND_HEX:  radix = 32'd16;
      KIND_CHAR: numeric = 1'b0;
      default:   return;
    endcase

    if (numeric) begin
      // zero still yields one digit
      do begin
        digits_rev.push_back(digit_set[mag % radix]);
        mag = mag / radix;
      end while (mag != 0);
      if (negative) body.push_back(CharMinus);
      while (digits_rev.size() != 0) body.push_back(digits_rev.pop_back());
    end else begin
      body.push_back(req.value[7:0]);
    end

    fill      = req.zero_pad ? CharZero : CharSpace;
    pad_count = (int'(req.field_width) > body.size()) ?
                int'(req.field_width) - body.size() : 0;
    skip      = 0;

    if (!req.left_adjust) begin
      // minus goes ahead of zero padding, not behind it
      if (numeric && req.zero_pad && negative) begin
        field.push_back(body[0]);
        skip = 1;
      end
      repeat (pad_count) field.push_back(fill);
    end
    for (int i = skip; i < body.size(); i++) field.push_back(body[i]);
    if (req.left_adjust) repeat (pad_count) field.push_back(fill);

    foreach (field[i]) begin
      r.out_char  = field[i];
      r.last_char = (i == field.size() - 1);
      pending_chars.push_back(r);
    end
  endfunction

  function automatic void add_row(input logic [31:0] value, input logic [2:0] kind,
                                  input logic [5:0] width, input bit left,
                                  input bit zeros, input string text);
    request_t r;
    r.value           = value;
    r.conversion_kind = kind;
    r.field_width     = width;
    r.left_adjust     = left;
    r.zero_pad        = zeros;
    row_req.push_back(r);
    row_text.push_back(text);
  endfunction

  function automatic request_t random_request();
    request_t r;
    int       pick;
    logic [31:0] extremes[5] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
    pick = $urandom_range(0, 9);
    case (pick)
      0:       r.value = extremes[$urandom_range(0, 4)];
      1, 2, 3: r.value = $urandom_range(0, 999);
      4:       r.value = -$urandom_range(1, 999);
      default: r.value = $urandom;
    endcase
    if ($urandom_range(0, 19) == 0) begin
      r.conversion_kind = 3'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));
    end else begin
      r.conversion_kind = 3'($urandom_range(KIND_SDEC, KIND_CHAR));
    end
    // mostly narrow fields, now and then up to the widest
    if ($urandom_range(0, 7) == 0) begin
      r.field_width = 6'($urandom_range(0, 63));
    end else begin
      r.field_width = 6'($urandom_range(0, 12));
    end
    r.left_adjust = 1'($urandom_range(0, 1));
    r.zero_pad    = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // one request: optional idle gap, then hold start until the core takes it.
  // start is driven once per edge so a back-to-back request never glitches it
  task automatic send_request(input request_t req, input string typed);
    int gap;
    gap = back_to_back ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= req;
    @(posedge clk);
    // busy is sampled before this edge's updates, same as the core sees it
    while (busy) @(posedge clk);
    if (typed.len() != 0) begin
      queue_typed_field(typed);
    end else begin
      predict_field(req);
    end
  endtask

  // result checker: every strobed character must match the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("unexpected char %h last %b",
                                  result.out_char, result.last_char));
      end else begin
        want = pending_chars.pop_front();
        if (result.out_char !== want.out_char) begin
          report_mismatch($sformatf("out_char %h, want %h", result.out_char, want.out_char));
        end
        if (result.last_char !== want.last_char) begin
          report_mismatch($sformatf("last_char %b, want %b (char %h)",
                                    result.last_char, want.last_char, want.out_char));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d chars outstanding",
               cycle_count, pending_chars.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    request_t req;
    int       counted;

    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // extremes of each kind
    add_row(32'h0000_0000, KIND_SDEC, 6'd0, 1'b0, 1'b0, "0");
    add_row(32'h8000_0000, KIND_SDEC, 6'd0, 1'b0, 1'b0, "-2147483648");
    add_row(32'hFFFF_FFFF, KIND_SDEC, 6'd0, 1'b0, 1'b0, "-1");
    add_row(32'h7FFF_FFFF, KIND_SDEC, 6'd0, 1'b0, 1'b0, "2147483647");
    add_row(32'hFFFF_FFFF, KIND_UDEC, 6'd0, 1'b0, 1'b0, "4294967295");
    add_row(32'h8000_0000, KIND_UDEC, 6'd0, 1'b0, 1'b0, "2147483648");
    add_row(32'hFFFF_FFFF, KIND_OCT,  6'd0, 1'b0, 1'b0, "37777777777");
    add_row(32'h0000_0000, KIND_OCT,  6'd0, 1'b0, 1'b0, "0");
    add_row(32'h0000_0008, KIND_OCT,  6'd2, 1'b0, 1'b0, "10");
    add_row(32'hFFFF_FFFF, KIND_HEX,  6'd0, 1'b0, 1'b0, "FFFFFFFF");
    add_row(32'hABCD_EF01, KIND_HEX,  6'd0, 1'b0, 1'b0, "ABCDEF01");
    add_row(32'h0000_0041, KIND_CHAR, 6'd0, 1'b0, 1'b0, "A");
    // character zero byte, and zero padding on a character
    add_row(32'hFFFF_FF00, KIND_CHAR, 6'd0, 1'b0, 1'b0, "");
    add_row(32'h1234_5678, KIND_CHAR, 6'd3, 1'b0, 1'b1, "00x");
    // sign placement against padding
    add_row(-32'sd42,      KIND_SDEC, 6'd6, 1'b0, 1'b1, "-00042");
    add_row(-32'sd42,      KIND_SDEC, 6'd6, 1'b1, 1'b1, "-42000");
    add_row(-32'sd42,      KIND_SDEC, 6'd6, 1'b0, 1'b0, "   -42");
    add_row(32'd7,         KIND_UDEC, 6'd5, 1'b1, 1'b0, "7    ");
    add_row(32'd123,       KIND_SDEC, 6'd2, 1'b0, 1'b0, "123");
    // widest fields
    add_row(32'h0000_001F, KIND_HEX,  6'd63, 1'b0, 1'b1, "");
    add_row(32'h8000_0000, KIND_SDEC, 6'd63, 1'b1, 1'b0, "");
    add_row(32'h8000_0000, KIND_SDEC, 6'd63, 1'b0, 1'b1, "");
    add_row(32'h0000_00FF, KIND_CHAR, 6'd63, 1'b1, 1'b1, "");
    // meaningless kinds are dropped
    add_row(32'hFFFF_FFFF, KIND_RSVD_A, 6'd63, 1'b1, 1'b1, "");
    add_row(32'h0000_0000, KIND_RSVD_B, 6'd0,  1'b0, 1'b0, "");
    add_row(32'h1234_5678, KIND_RSVD_C, 6'd10, 1'b0, 1'b1, "");

    for (int i = 0; i < row_req.size(); i++) send_request(row_req[i], row_text[i]);

    // random part; dropped kinds do not count toward the total
    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 39) == 0) back_to_back = ~back_to_back;
      req = random_request();
      send_request(req, "");
      if (req.conversion_kind <= KIND_CHAR) counted++;
    end
    start <= 1'b0;

    // wait for the last field, then watch for stray characters
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/iff_pkg.sv
rtl/integer_field_formatter_core.sv
tb/testbench.sv
